// ----- design/kcs_pkg.sv -----
// ----------------------------------------------------------------------------
// kcs_pkg - shared types and constants of the Koch curve subdivider
// Point record passed between subdivision cells, cell state codes, the
// fixed-point constants and the saturation helper.
// ----------------------------------------------------------------------------
package kcs_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned LEVELS_W = 2;

  // sqrt(3)/2 in Q1.30, unsigned
  localparam logic [30:0] SQRT3_HALF_Q30 = 31'd929887697;
  // 0.5 in Q34.30, used for round-half-away-from-zero
  localparam logic [63:0] HALF_Q30 = 64'd536870912;
  // floor((2^32 - 1) / 3): reciprocal of three for the third estimate
  localparam logic [31:0] RECIP3 = 32'h5555_5555;

  typedef struct packed {
    logic                      last;  // last point caused by this vertex
    logic                      clr;   // first point of a new polyline
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pt_t;

  typedef enum logic [3:0] {
    CELL_IDLE,
    CELL_DIV,
    CELL_THIRD,
    CELL_ENDS,
    CELL_VEC,
    CELL_MUL,
    CELL_SUM,
    CELL_RND,
    CELL_PEAK,
    CELL_EMIT1,
    CELL_EMIT2,
    CELL_EMIT3,
    CELL_EMIT4
  } cell_state_e;

  // clamp a 35-bit signed value to the 32-bit coordinate range
  function automatic logic signed [COORD_W-1:0] sat35(logic signed [34:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[34] == 1'b0 && v[33:31] != 3'b000) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v[34] == 1'b1 && v[33:31] != 3'b111) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/kcs_cell.sv -----
// ----------------------------------------------------------------------------
// kcs_cell - one Koch subdivision level
// Keeps the last point received; for each point that follows a kept one,
// emits the one-third point, the peak, the two-thirds point and the point.
// ----------------------------------------------------------------------------
module kcs_cell
  import kcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enable_i,     // level active, else plain pass-through
  input  logic clear_i,      // drop the kept point
  input  logic in_valid_i,
  output logic in_ready_o,
  input  pt_t  in_pt_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output pt_t  out_pt_o
);

  cell_state_e state_q, state_d;
  logic        has_prev_q;
  logic        out_valid_q;
  pt_t         out_pt_q;

  logic signed [31:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic               last_q, clr_q, byp_q;
  logic [32:0]        n_x_q, n_y_q;
  logic [31:0]        q0_x_q, q0_y_q;
  logic               neg_x_q, neg_y_q;
  logic signed [32:0] third_x_q, third_y_q;
  logic signed [31:0] p1_x_q, p1_y_q, p3_x_q, p3_y_q, pk_x_q, pk_y_q;
  logic signed [32:0] v_x_q, v_y_q;
  logic signed [63:0] pm_x_q, pm_y_q;
  logic signed [63:0] t_x_q, t_y_q;
  logic signed [33:0] off_x_q, off_y_q;

  logic               accept, load, first;
  logic signed [32:0] d_x, d_y;
  logic [32:0]        mag_x, mag_y, n_x, n_y;
  logic [64:0]        prod_x, prod_y;
  logic [33:0]        r_x, r_y;
  logic [31:0]        q_x, q_y;
  logic signed [32:0] third_x, third_y;
  logic signed [31:0] p1_x, p1_y, p3_x, p3_y, pk_x, pk_y;
  logic signed [32:0] v_x, v_y;
  logic signed [31:0] s_sig;
  logic signed [64:0] pm_x, pm_y;
  logic signed [63:0] vsh_x, vsh_y, t_x, t_y, rs_x, rs_y;
  pt_t                emit_pt;

  assign in_ready_o  = (state_q == CELL_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign load        = ~out_valid_q | out_ready_i;
  assign first       = ~enable_i | in_pt_i.clr | ~has_prev_q;
  assign out_valid_o = out_valid_q;
  assign out_pt_o    = out_pt_q;

  // exact thirds: round(d / 3) = sign(d) * floor((|d| + 1) / 3)
  always_comb begin
    d_x    = {cur_x_q[31], cur_x_q} - {prev_x_q[31], prev_x_q};
    d_y    = {cur_y_q[31], cur_y_q} - {prev_y_q[31], prev_y_q};
    mag_x  = d_x[32] ? 33'(-d_x) : 33'(d_x);
    mag_y  = d_y[32] ? 33'(-d_y) : 33'(d_y);
    n_x    = mag_x + 33'd1;
    n_y    = mag_y + 33'd1;
    prod_x = n_x * RECIP3;
    prod_y = n_y * RECIP3;
    // estimate is low by at most one
    r_x    = {1'b0, n_x_q} - ({1'b0, q0_x_q, 1'b0} + {2'b00, q0_x_q});
    r_y    = {1'b0, n_y_q} - ({1'b0, q0_y_q, 1'b0} + {2'b00, q0_y_q});
    q_x    = (r_x >= 34'd3) ? q0_x_q + 32'd1 : q0_x_q;
    q_y    = (r_y >= 34'd3) ? q0_y_q + 32'd1 : q0_y_q;
    third_x = neg_x_q ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    third_y = neg_y_q ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
  end

  // segment end points, rotation by minus 60 degrees and rounding
  always_comb begin
    p1_x  = sat35(35'(prev_x_q) + 35'(third_x_q));
    p1_y  = sat35(35'(prev_y_q) + 35'(third_y_q));
    p3_x  = sat35(35'(cur_x_q) - 35'(third_x_q));
    p3_y  = sat35(35'(cur_y_q) - 35'(third_y_q));
    v_x   = {p1_x_q[31], p1_x_q} - {prev_x_q[31], prev_x_q};
    v_y   = {p1_y_q[31], p1_y_q} - {prev_y_q[31], prev_y_q};
    s_sig = $signed({1'b0, SQRT3_HALF_Q30});
    pm_x  = v_x_q * s_sig;
    pm_y  = v_y_q * s_sig;
    vsh_x = {{2{v_x_q[32]}}, v_x_q, 29'd0};
    vsh_y = {{2{v_y_q[32]}}, v_y_q, 29'd0};
    t_x   = vsh_x + pm_y_q;
    t_y   = vsh_y - pm_x_q;
    // half away from zero: (t + half - sign) >>> 30
    rs_x  = t_x_q + $signed(HALF_Q30) - $signed({63'd0, t_x_q[63]});
    rs_y  = t_y_q + $signed(HALF_Q30) - $signed({63'd0, t_y_q[63]});
    pk_x  = sat35(35'(p1_x_q) + 35'(off_x_q));
    pk_y  = sat35(35'(p1_y_q) + 35'(off_y_q));
  end

  always_comb begin
    state_d = state_q;
    emit_pt = '{last: last_q, clr: clr_q, y: cur_y_q, x: cur_x_q};
    case (state_q)
      CELL_IDLE: begin
        if (accept) begin
          state_d = first ? CELL_EMIT4 : CELL_DIV;
        end
      end
      CELL_DIV:   state_d = CELL_THIRD;
      CELL_THIRD: state_d = CELL_ENDS;
      CELL_ENDS:  state_d = CELL_VEC;
      CELL_VEC:   state_d = CELL_MUL;
      CELL_MUL:   state_d = CELL_SUM;
      CELL_SUM:   state_d = CELL_RND;
      CELL_RND:   state_d = CELL_PEAK;
      CELL_PEAK:  state_d = CELL_EMIT1;
      CELL_EMIT1: begin
        emit_pt = '{last: 1'b0, clr: 1'b0, y: p1_y_q, x: p1_x_q};
        if (load) state_d = CELL_EMIT2;
      end
      CELL_EMIT2: begin
        emit_pt = '{last: 1'b0, clr: 1'b0, y: pk_y_q, x: pk_x_q};
        if (load) state_d = CELL_EMIT3;
      end
      CELL_EMIT3: begin
        emit_pt = '{last: 1'b0, clr: 1'b0, y: p3_y_q, x: p3_x_q};
        if (load) state_d = CELL_EMIT4;
      end
      CELL_EMIT4: begin
        if (load) state_d = CELL_IDLE;
      end
      default: state_d = CELL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CELL_IDLE;
      has_prev_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_i) begin
        has_prev_q <= 1'b0;
      end else if (state_q == CELL_EMIT4 && load && !byp_q) begin
        has_prev_q <= 1'b1;
      end
      if (load) begin
        out_valid_q <= (state_q == CELL_EMIT1) || (state_q == CELL_EMIT2) ||
                       (state_q == CELL_EMIT3) || (state_q == CELL_EMIT4);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_x_q <= in_pt_i.x;
      cur_y_q <= in_pt_i.y;
      last_q  <= in_pt_i.last;
      clr_q   <= in_pt_i.clr;
      byp_q   <= ~enable_i;
    end
    if (state_q == CELL_DIV) begin
      n_x_q   <= n_x;
      n_y_q   <= n_y;
      q0_x_q  <= prod_x[63:32];
      q0_y_q  <= prod_y[63:32];
      neg_x_q <= d_x[32];
      neg_y_q <= d_y[32];
    end
    if (state_q == CELL_THIRD) begin
      third_x_q <= third_x;
      third_y_q <= third_y;
    end
    if (state_q == CELL_ENDS) begin
      p1_x_q <= p1_x;
      p1_y_q <= p1_y;
      p3_x_q <= p3_x;
      p3_y_q <= p3_y;
    end
    if (state_q == CELL_VEC) begin
      v_x_q <= v_x;
      v_y_q <= v_y;
    end
    if (state_q == CELL_MUL) begin
      pm_x_q <= pm_x[63:0];
      pm_y_q <= pm_y[63:0];
    end
    if (state_q == CELL_SUM) begin
      t_x_q <= t_x;
      t_y_q <= t_y;
    end
    if (state_q == CELL_RND) begin
      off_x_q <= rs_x[63:30];
      off_y_q <= rs_y[63:30];
    end
    if (state_q == CELL_PEAK) begin
      pk_x_q <= pk_x;
      pk_y_q <= pk_y;
    end
    if (state_q == CELL_EMIT4 && load && !byp_q) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
    if (load) begin
      out_pt_q <= emit_pt;
    end
  end

endmodule

// ----- design/koch_curve_subdivider.sv -----
// ----------------------------------------------------------------------------
// koch_curve_subdivider - streaming Koch curve subdivision of a polyline
// Vertices in signed Q16.16 go in, subdivided and saturated vertices come out.
// ----------------------------------------------------------------------------
// Each input vertex runs through a row of MAX_LEVELS subdivision cells; the
// first 'levels' cells subdivide, the rest just pass points on. A cell keeps
// the last point it saw and, for each new point, sends the one-third point,
// the peak (one-third vector turned by minus 60 degrees, y downward), the
// two-thirds point and the new point to its neighbour. So a vertex gives one
// output transfer if it opens a polyline (tuser set, or first after reset or
// a levels write), else 4^levels transfers; tlast marks the last of them.
// Per segment a cell steps through its DIV, THIRD, ENDS, VEC, MUL, SUM, RND
// and PEAK states (divide by three, saturation, two 33x32 multiplies,
// rounding), then hands its points on one at a time as the next cell takes
// them; it takes a new point only once its last one is in its output
// register. The deepest active cell sets the pace. The master side is a
// register per cell, so the block keeps working while a result waits.
// Writing levels drops all kept points; write only while idle.
// Levels beyond MAX_LEVELS act as MAX_LEVELS.
module koch_curve_subdivider
  import kcs_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 3   // 1 to 3 subdivision cells
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: subdivision levels
  input  logic                cfg_we_i,
  input  logic [LEVELS_W-1:0] cfg_wdata_i,
  // vertex input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // [31:0] point_x, [63:32] point_y
  input  logic                s_axis_tuser,   // starts_polyline
  // vertex output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // [31:0] out_x, [63:32] out_y
  output logic                m_axis_tlast    // run_end
);

  logic [LEVELS_W-1:0] levels_q;

  // links between cells: index 0 is the input, MAX_LEVELS the output
  logic                valid_w [MAX_LEVELS+1];
  logic                ready_w [MAX_LEVELS+1];
  pt_t                 pt_w    [MAX_LEVELS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= '0;
    end else if (cfg_we_i) begin
      levels_q <= cfg_wdata_i;
    end
  end

  // an input vertex is a run of one point, so it carries last
  assign valid_w[0]    = s_axis_tvalid;
  assign s_axis_tready = ready_w[0];
  assign pt_w[0]       = '{last: 1'b1, clr: s_axis_tuser,
                           y: $signed(s_axis_tdata[63:32]),
                           x: $signed(s_axis_tdata[31:0])};

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    logic enable;
    assign enable = (levels_q > LEVELS_W'(k));

    kcs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .enable_i    (enable),
      .clear_i     (cfg_we_i),
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .in_pt_i     (pt_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .out_pt_o    (pt_w[k+1])
    );
  end

  assign m_axis_tvalid       = valid_w[MAX_LEVELS];
  assign ready_w[MAX_LEVELS] = m_axis_tready;
  assign m_axis_tdata        = {pt_w[MAX_LEVELS].y, pt_w[MAX_LEVELS].x};
  assign m_axis_tlast        = pt_w[MAX_LEVELS].last;

endmodule

// ----- tb/koch_curve_subdivider_tb.sv -----
// ----------------------------------------------------------------------------
// koch_curve_subdivider_tb - self-checking bench for the Koch curve subdivider
// Streams polylines into the block under every levels setting and checks each
// output vertex, field by field, against an in-bench subdivision predictor.
// Both stream sides idle at random; one phase holds the output off for long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module koch_curve_subdivider_tb;

  localparam int unsigned N_CELLS = 3;

  // cycles with no transfer at all before the run is declared hung; the worst
  // honest gap is the long output hold-off plus a level-3 segment's arithmetic
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  localparam longint ROOT3_HALF_Q30 = 64'sd929887697;
  localparam longint ROUND_HALF_Q30 = 64'sd536870912;
  localparam longint ONE_Q30 = 64'sd1073741824;

  localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_ONE = 32'sh0001_0000;

  typedef struct packed {
    longint x;
    longint y;
  } coord_pt_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } out_vertex_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [kcs_pkg::LEVELS_W-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [63:0]                  s_axis_tdata = '0;  // [31:0] point_x, [63:32] point_y
  logic                         s_axis_tuser = 1'b0;  // starts_polyline
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [63:0]                  m_axis_tdata;  // [31:0] out_x, [63:32] out_y
  logic                         m_axis_tlast;  // run_end

  always #2ns clk_i = ~clk_i;

  koch_curve_subdivider #(
    .MAX_LEVELS(N_CELLS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Subdivision predictor: its own levels copy and one kept point per cell
  // --------------------------------------------------------------------------
  logic [kcs_pkg::LEVELS_W-1:0] levels_setting = '0;
  coord_pt_t                    kept_pt    [N_CELLS];
  logic                         kept_valid [N_CELLS];
  out_vertex_t                  expected_vertices[$];

  int  n_errors = 0;
  bit  source_idle = 1'b1;  // sender gaps between transfers
  bit  sink_idle = 1'b1;    // receiver stalls between transfers
  int  hold_left = 0;       // long output hold-off, counted down by the receiver

  function automatic longint clamp32(input longint v);
    if (v > longint'(C_MAX)) return longint'(C_MAX);
    if (v < longint'(C_MIN)) return longint'(C_MIN);
    return v;
  endfunction

  // exact thirds: nearest integer, a tie cannot occur
  function automatic longint third_round(input longint d);
    if (d >= 0) return (d + 1) / 3;
    return -((-d + 1) / 3);
  endfunction

  // divide by 2^30, half away from zero
  function automatic longint round_q30(input longint t);
    if (t >= 0) return (t + ROUND_HALF_Q30) / ONE_Q30;
    return -((-t + ROUND_HALF_Q30) / ONE_Q30);
  endfunction

  function automatic void forget_kept_points();
    int k;
    for (k = 0; k < N_CELLS; k++) begin
      kept_pt[k] = '0;
      kept_valid[k] = 1'b0;
    end
  endfunction

  // Each active cell turns its point list into the next one, in order; this is
  // the same sequence as the depth-first chain in hardware.
  function automatic void subdivide_vertex(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic start);
    coord_pt_t   cur[$];
    coord_pt_t   nxt[$];
    coord_pt_t   a, b, p1, pk, p3;
    longint      tx, ty, vx, vy;
    int          depth, k, i;
    out_vertex_t v;
    if (start) forget_kept_points();
    depth = (levels_setting > N_CELLS) ? N_CELLS : levels_setting;
    cur.push_back('{longint'(px), longint'(py)});
    for (k = 0; k < depth; k++) begin
      nxt.delete();
      for (i = 0; i < cur.size(); i++) begin
        b = cur[i];
        if (!kept_valid[k]) begin
          // opening point of the cell: stored and handed on alone
          kept_valid[k] = 1'b1;
          kept_pt[k] = b;
          nxt.push_back(b);
        end else begin
          a = kept_pt[k];
          tx = third_round(b.x - a.x);
          ty = third_round(b.y - a.y);
          p1.x = clamp32(a.x + tx);
          p1.y = clamp32(a.y + ty);
          p3.x = clamp32(b.x - tx);
          p3.y = clamp32(b.y - ty);
          // peak offset from the saturated one-third point, turned -60 deg
          vx = p1.x - a.x;
          vy = p1.y - a.y;
          pk.x = clamp32(p1.x + round_q30(vx * ROUND_HALF_Q30 + vy * ROOT3_HALF_Q30));
          pk.y = clamp32(p1.y + round_q30(vy * ROUND_HALF_Q30 - vx * ROOT3_HALF_Q30));
          kept_pt[k] = b;
          nxt.push_back(p1);
          nxt.push_back(pk);
          nxt.push_back(p3);
          nxt.push_back(b);
        end
      end
      cur = nxt;
    end
    for (i = 0; i < cur.size(); i++) begin
      v.x = 32'(cur[i].x);
      v.y = 32'(cur[i].y);
      v.last = (i == cur.size() - 1);
      expected_vertices.push_back(v);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, long hold-off on request, checks every transfer
  // --------------------------------------------------------------------------
  int          wait_left = 0;
  out_vertex_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_vertices.size() == 0) begin
          $error("unexpected output vertex x=%0d y=%0d",
                 $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
          n_errors++;
        end else begin
          want = expected_vertices.pop_front();
          if (m_axis_tdata[31:0] !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, $signed(m_axis_tdata[31:0]));
            n_errors++;
          end
          if (m_axis_tdata[63:32] !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, $signed(m_axis_tdata[63:32]));
            n_errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("run_end: expected %0d, got %0d", want.last, m_axis_tlast);
            n_errors++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && m_axis_tvalid) begin
        // transfer done: draw the stall before the next one
        wait_left = sink_idle ? $urandom_range(0, 14) : 0;
        m_axis_tready <= (wait_left == 0);
      end else if (!m_axis_tready) begin
        if (wait_left > 0) wait_left--;
        if (wait_left == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer or register write restarts the count
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("koch_curve_subdivider_tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared sender tasks; all are entered just after a rising edge
  // --------------------------------------------------------------------------
  task automatic send_vertex(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic start);
    int gap;
    gap = source_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    subdivide_vertex(px, py, start);
  endtask

  // every output back and the cells quiet
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_levels(input logic [kcs_pkg::LEVELS_W-1:0] lv);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    levels_setting = lv;
    forget_kept_points();  // a write drops every kept point
  endtask

  // mostly moderate coordinates, some raw 32-bit and some at the rails
  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      5, 6, 7:       return $signed($urandom);
      8:             return $urandom_range(0, 1) ? C_MAX : C_MIN;
      default:       return $urandom_range(0, 1) ? C_MAX - $urandom_range(0, 4095)
                                                 : C_MIN + $urandom_range(0, 4095);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // levels at reset value: every vertex comes straight through
  task automatic test_levels_zero_passthrough();
    send_vertex('0, '0, 1'b1);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b0);
    send_vertex(-32'sd1, 32'sd1, 1'b0);
  endtask

  // hand-picked segments: plain thirds, polyline restarts, rail-to-rail spans
  task automatic test_directed_subdivision();
    write_levels(2'd1);
    send_vertex('0, '0, 1'b0);             // first after a write: single point
    send_vertex(3 * C_ONE, '0, 1'b0);
    send_vertex(3 * C_ONE, 3 * C_ONE, 1'b1);  // restart mid-polyline
    send_vertex(C_MIN, C_MIN, 1'b1);
    send_vertex(C_MAX, C_MAX, 1'b0);       // widest span
    send_vertex(C_MIN, C_MAX, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(32'sd1, -32'sd1, 1'b0);
    write_levels(2'd3);
    send_vertex('0, '0, 1'b1);
    send_vertex(9 * C_ONE, '0, 1'b0);      // full 64-point run
    send_vertex(C_MAX, C_MIN, 1'b0);
    write_levels(2'd2);
    send_vertex('0, '0, 1'b1);
    send_vertex('0, 9 * C_ONE, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b0);
  endtask

  // phases of random polylines, each under a fresh levels setting
  task automatic test_random_polylines();
    int                 phase, n;
    logic               start;
    logic signed [31:0] px, py;
    for (phase = 0; phase < 12; phase++) begin
      write_levels(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
      // some phases run one side or both without idling
      source_idle = (phase % 4 != 1);
      sink_idle   = (phase % 3 != 0);
      px = random_coord();
      py = random_coord();
      for (n = 0; n < 28; n++) begin
        start = (n == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
        if (start || $urandom_range(0, 3) == 0) begin
          px = random_coord();
          py = random_coord();
        end else begin
          // walk on from the last vertex
          px = px + $signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
          py = py + $signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
        end
        send_vertex(px, py, start);
      end
    end
    source_idle = 1'b1;
    sink_idle   = 1'b1;
  endtask

  // output held off while vertices keep coming, so the input must stall
  task automatic test_output_backpressure();
    int n;
    write_levels(2'd1);
    source_idle = 1'b0;
    hold_left = HOLD_OFF_CYCLES;
    for (n = 0; n < 24; n++) send_vertex(random_coord(), random_coord(), n == 0);
    source_idle = 1'b1;
  endtask

  initial begin
    forget_kept_points();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_levels_zero_passthrough();
    test_directed_subdivision();
    test_output_backpressure();
    test_random_polylines();

    wait_idle();
    if (n_errors == 0 && expected_vertices.size() == 0) begin
      $display("koch_curve_subdivider_tb passed");
    end else begin
      $display("koch_curve_subdivider_tb failed");
    end
    $finish;
  end

endmodule
